[rtl/core/dbms_pkg.sv]
// shared types and constants for the detection box match select block
`default_nettype none

package dbms_pkg;

    localparam int MAX_DETECTIONS = 64;
    localparam int COORD_BITS     = 16;
    localparam int CNT_W          = $clog2(MAX_DETECTIONS + 1);
    localparam int IDX_W          = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;

    localparam logic [15:0] COORD_MASK = 16'((33'd1 << COORD_BITS) - 33'd1);
    localparam logic [15:0] CONF_RESET = 16'd13107;

    typedef struct packed {
        logic [15:0] cell_x;
        logic [15:0] cell_y;
        logic [15:0] cell_w;
        logic [15:0] cell_h;
        logic [15:0] joint_x;
        logic [15:0] joint_y;
        logic        joint_present;
        logic [15:0] confidence;
        logic        last_joint;
        logic        last_detection;
    } t_in;

    typedef struct packed {
        logic       found;
        logic [5:0] best_detection;
    } t_out;

    typedef struct packed {
        logic             valid;
        logic             last_d;
        logic             hit;
        logic [15:0]      small_h;
        logic [15:0]      large_h;
        logic [IDX_W-1:0] index;
    } t_close;

endpackage

`default_nettype wire

[rtl/core/detection_box_match_select_top.sv]
// top level: input register, box accumulate, best select and result register
// a closing request passes the input and close registers, then the result register
// throughput: one request per cycle unless stalled, bounded by the running box
//   update loop and the best ratio compare loop with its two 16x16 multipliers
// a waiting result stalls intake only once a further end-of-query request reaches it
// reset: synchronous active low, clears query state and sets the threshold to 13107
`default_nettype none

module detection_box_match_select_top
    import dbms_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in         i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out             o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata
);

    logic [15:0] r_conf_threshold;
    logic        r_in_valid;
    t_in         r_in;
    logic        r_out_valid;
    t_out        r_out;

    logic        adv;
    t_close      close_req;
    t_out        result;

    assign adv = !(close_req.valid && close_req.last_d && r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_conf_threshold <= CONF_RESET;
        end else if (i_cfg_we) begin
            r_conf_threshold <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (adv) begin
            r_in_valid <= i_in_valid;
            r_in       <= i_in_data;
        end
    end

    dbms_box_acc u_box (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_adv            (adv),
        .i_valid          (r_in_valid),
        .i_item           (r_in),
        .i_conf_threshold (r_conf_threshold),
        .o_close          (close_req)
    );

    dbms_best_sel u_best (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_close  (close_req),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && close_req.valid && close_req.last_d) begin
            r_out_valid <= 1'b1;
            r_out       <= result;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_ready  = adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("pending result overwritten");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_out_valid && close_req.valid && close_req.last_d))
        else $error("intake stalled without a pending result");

    a_found_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.found) |-> (r_out.best_detection == 6'd0))
        else $error("index reported without a match");

endmodule

`default_nettype wire

[rtl/core/dbms_box_acc.sv]
// running joint box, detection close and cell overlap test
`default_nettype none

module dbms_box_acc
    import dbms_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_adv,
    input  wire logic        i_valid,
    input  wire t_in         i_item,
    input  wire logic [15:0] i_conf_threshold,
    output t_close           o_close
);

    logic [15:0]      r_min_x, r_min_y, r_max_x, r_max_y;
    logic             r_have;
    logic [CNT_W-1:0] r_cnt;
    t_close           r_close;

    logic [15:0]      n_min_x, n_min_y, n_max_x, n_max_y;
    logic             n_have;
    logic             counted, closing, eligible, ov_x, ov_y;
    logic [15:0]      jx, jy, bw, bh, x1, y1;
    logic [16:0]      x2, y2;
    t_close           n_close;

    always_comb begin
        jx      = i_item.joint_x & COORD_MASK;
        jy      = i_item.joint_y & COORD_MASK;
        counted = i_item.joint_present && (i_item.confidence > i_conf_threshold);
        closing = i_item.last_joint || i_item.last_detection;

        n_min_x = r_min_x;
        n_min_y = r_min_y;
        n_max_x = r_max_x;
        n_max_y = r_max_y;
        n_have  = r_have;
        if (counted) begin
            if (r_have) begin
                n_min_x = (jx < r_min_x) ? jx : r_min_x;
                n_min_y = (jy < r_min_y) ? jy : r_min_y;
                n_max_x = (jx > r_max_x) ? jx : r_max_x;
                n_max_y = (jy > r_max_y) ? jy : r_max_y;
            end else begin
                n_min_x = jx;
                n_min_y = jy;
                n_max_x = jx;
                n_max_y = jy;
            end
            n_have = 1'b1;
        end

        bw = n_max_x - n_min_x;
        bh = n_max_y - n_min_y;
        x1 = (i_item.cell_x > n_min_x) ? i_item.cell_x : n_min_x;
        y1 = (i_item.cell_y > n_min_y) ? i_item.cell_y : n_min_y;
        x2 = {1'b0, i_item.cell_x} + {1'b0, i_item.cell_w};
        if ({1'b0, n_max_x} < x2) x2 = {1'b0, n_max_x};
        y2 = {1'b0, i_item.cell_y} + {1'b0, i_item.cell_h};
        if ({1'b0, n_max_y} < y2) y2 = {1'b0, n_max_y};
        ov_x = x2 > {1'b0, x1};
        ov_y = y2 > {1'b0, y1};

        eligible = n_have && (r_cnt < CNT_W'(MAX_DETECTIONS));

        n_close.valid   = i_valid && closing;
        n_close.last_d  = i_item.last_detection;
        n_close.hit     = eligible && (i_item.cell_w != 16'd0) && (i_item.cell_h != 16'd0)
                          && (bw != 16'd0) && (bh != 16'd0) && ov_x && ov_y;
        n_close.small_h = (i_item.cell_h < bh) ? i_item.cell_h : bh;
        n_close.large_h = (i_item.cell_h > bh) ? i_item.cell_h : bh;
        n_close.index   = r_cnt[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_x       <= '0;
            r_min_y       <= '0;
            r_max_x       <= '0;
            r_max_y       <= '0;
            r_have        <= 1'b0;
            r_cnt         <= '0;
            r_close.valid <= 1'b0;
        end else if (i_adv) begin
            r_close <= n_close;
            if (i_valid) begin
                if (closing) begin
                    r_min_x <= '0;
                    r_min_y <= '0;
                    r_max_x <= '0;
                    r_max_y <= '0;
                    r_have  <= 1'b0;
                    if (i_item.last_detection) begin
                        r_cnt <= '0;
                    end else if (r_cnt < CNT_W'(MAX_DETECTIONS)) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end else begin
                    r_min_x <= n_min_x;
                    r_min_y <= n_min_y;
                    r_max_x <= n_max_x;
                    r_max_y <= n_max_y;
                    r_have  <= n_have;
                end
            end
        end
    end

    assign o_close = r_close;

    a_empty_box_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_have |-> (r_min_x == 16'd0 && r_max_x == 16'd0 && r_min_y == 16'd0
                     && r_max_y == 16'd0))
        else $error("empty box holds coordinates");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_DETECTIONS))
        else $error("detection count beyond limit");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_valid && closing) |=> !r_have)
        else $error("box not cleared after close");

endmodule

`default_nettype wire

[rtl/core/dbms_best_sel.sv]
// best height ratio selection over closed detections
`default_nettype none

module dbms_best_sel
    import dbms_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_adv,
    input  wire t_close i_close,
    output t_out        o_result
);

    logic             r_found;
    logic [IDX_W-1:0] r_idx;
    logic [15:0]      r_small, r_large;

    logic [31:0]      lhs, rhs;
    logic             win;

    always_comb begin
        lhs = 32'(i_close.small_h) * 32'(r_large);
        rhs = 32'(r_small) * 32'(i_close.large_h);
        win = i_close.valid && i_close.hit && (lhs > rhs);

        o_result.found          = win || r_found;
        o_result.best_detection = win ? 6'(i_close.index) : (r_found ? 6'(r_idx) : 6'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_idx   <= '0;
            r_small <= 16'd0;
            r_large <= 16'd1;
        end else if (i_adv && i_close.valid) begin
            if (i_close.last_d) begin
                r_found <= 1'b0;
                r_idx   <= '0;
                r_small <= 16'd0;
                r_large <= 16'd1;
            end else if (win) begin
                r_found <= 1'b1;
                r_idx   <= i_close.index;
                r_small <= i_close.small_h;
                r_large <= i_close.large_h;
            end
        end
    end

    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_found |-> (r_idx == '0 && r_small == 16'd0))
        else $error("best index set without a match");

    a_large_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_large != 16'd0)
        else $error("best ratio denominator is zero");

    a_query_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_adv && i_close.valid && i_close.last_d) |=> (!r_found && r_large == 16'd1))
        else $error("best state not cleared at end of query");

endmodule

`default_nettype wire
